### rtl/mccs_pkg.sv
// Shared types and constants of the memory card slave protocol core.
`timescale 1ns / 1ps
package mccs_pkg;
	localparam int SECTOR_COUNT = 1024;
	localparam int SECTOR_BYTES = 128;
	localparam int MEM_DEPTH = SECTOR_COUNT * SECTOR_BYTES;
	localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int BUF_AW = $clog2(SECTOR_BYTES);
	localparam logic [16:0] SECTOR_LIM = 17'(SECTOR_COUNT);

	localparam logic [7:0] B_ACCESS = 8'h81;
	localparam logic [7:0] B_READ = 8'h52;
	localparam logic [7:0] B_WRITE = 8'h57;
	localparam logic [7:0] B_PING = 8'h20;
	localparam logic [7:0] B_TITLE = 8'h21;
	localparam logic [7:0] R_FF = 8'hFF;
	localparam logic [7:0] R_ZERO = 8'h00;
	localparam logic [7:0] R_ACK1 = 8'h5A;
	localparam logic [7:0] R_ACK2 = 8'h5D;
	localparam logic [7:0] R_CMDACK = 8'h5C;
	localparam logic [7:0] R_GOOD = 8'h47;
	localparam logic [7:0] R_BADSUM = 8'h4E;
	localparam logic [7:0] R_FLAG = 8'h08;

	localparam logic [8:0] T_DATA_LAST_RD = 9'd135;
	localparam logic [8:0] T_SUM_RD = 9'd136;
	localparam logic [8:0] T_END_RD = 9'd137;
	localparam logic [8:0] T_DATA_LAST_WR = 9'd132;
	localparam logic [8:0] T_SUM_WR = 9'd133;
	localparam logic [8:0] T_ACK_WR = 9'd134;
	localparam logic [8:0] T_STAT_WR = 9'd135;
	localparam logic [8:0] T_MAX = 9'h1FF;

	typedef enum logic [6:0] {
		C_IDLE   = 7'b0000001,
		C_ACCESS = 7'b0000010,
		C_READ   = 7'b0000100,
		C_WRITE  = 7'b0001000,
		C_PING   = 7'b0010000,
		C_TITLE  = 7'b0100000,
		C_ERROR  = 7'b1000000
	} cmd_t;

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_EXEC   = 4'b0010,
		S_RDWAIT = 4'b0100,
		S_COMMIT = 4'b1000
	} bstate_t;

	typedef struct packed {
		logic       release_sel;
		logic [7:0] data;
	} req_t;
endpackage

### rtl/mccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/mccs_front.sv
// Request intake: classify and queue requests for the back end.
`timescale 1ns / 1ps
module mccs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          op,
	input  logic [7:0]    data_in,
	output logic          busy,
	output logic          head_valid,
	output mccs_pkg::req_t head,
	input  logic          pop
);
	import mccs_pkg::*;

	req_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head_valid = (cnt_q != 2'd0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= '{release_sel: op, data: data_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### rtl/mccs_back.sv
// Protocol engine: executes queued requests against card memory and buffer.
`timescale 1ns / 1ps
module mccs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mccs_pkg::req_t head,
	output logic           pop,
	output logic           done,
	output logic [7:0]     data_out
);
	import mccs_pkg::*;

	bstate_t          st_q;
	cmd_t             cmd_q;
	logic [8:0]       tick_q;
	logic [15:0]      sec_q;
	logic [6:0]       off_q;
	logic [7:0]       crcv_q;
	logic [7:0]       crun_q;
	logic             pend_q;
	logic             dir_q;
	logic [7:0]       tlen_q;
	logic [MEM_AW-1:0] clr_q;
	logic [BUF_AW:0]  ccnt_q;

	cmd_t        eff, n_cmd;
	logic [8:0]  n_tick, tick_inc;
	logic [15:0] n_sec;
	logic [6:0]  n_off;
	logic [7:0]  n_crun, n_crcv, n_tlen, r, d;
	logic        n_pend, n_dir, emit, go_rd, go_commit, sec_ok;
	logic        buf_we;
	logic [BUF_AW-1:0] buf_waddr, buf_raddr;
	logic [7:0]  buf_rdata, mem_rdata, mem_wdata;
	logic        mem_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [6:0]  cidx;
	logic [22:0] rd_full, wr_full;
	logic [8:0]  tsub;

	assign d = head.data;
	assign sec_ok = {1'b0, sec_q} < SECTOR_LIM;
	assign tick_inc = (tick_q == T_MAX) ? tick_q : tick_q + 9'd1;
	assign tsub = tick_q - 9'd3;
	assign cidx = 7'(ccnt_q - 8'd1);
	assign rd_full = {sec_q, off_q};
	assign wr_full = {sec_q, cidx};
	assign mem_raddr = rd_full[MEM_AW-1:0];
	assign buf_raddr = ccnt_q[BUF_AW-1:0];

	always_comb begin
		eff = cmd_q;
		if (cmd_q == C_ACCESS) begin
			if (d == B_READ) eff = C_READ;
			else if (d == B_WRITE) eff = C_WRITE;
			else if (d == B_PING) eff = C_PING;
			else if (d == B_TITLE) eff = C_TITLE;
			else eff = C_ERROR;
		end
		n_cmd = eff;
		n_tick = tick_inc;
		n_sec = sec_q;
		n_off = off_q;
		n_crun = crun_q;
		n_crcv = crcv_q;
		n_pend = pend_q;
		n_dir = dir_q;
		n_tlen = tlen_q;
		r = R_FF;
		go_rd = 1'b0;
		go_commit = 1'b0;
		buf_we = 1'b0;
		buf_waddr = BUF_AW'(tick_q - 9'd5);
		if (head.release_sel) begin
			n_cmd = C_IDLE;
			n_tick = 9'd0;
			n_off = 7'd0;
			r = R_FF;
			if (pend_q) begin
				if (sec_ok) go_commit = 1'b1;
				else n_pend = 1'b0;
			end
		end else begin
			case (eff)
				C_IDLE: begin
					n_cmd = (d == B_ACCESS) ? C_ACCESS : C_ERROR;
					n_tick = tick_q;
					r = dir_q ? R_FLAG : R_ZERO;
				end
				C_READ: begin
					if (tick_q == 9'd0) r = R_ACK1;
					else if (tick_q == 9'd1) r = R_ACK2;
					else if (tick_q == 9'd2) r = R_ZERO;
					else if (tick_q == 9'd3) begin
						n_sec = {d, 8'd0};
						r = d;
					end else if (tick_q == 9'd4) begin
						n_sec = sec_q | {8'd0, d};
						r = R_CMDACK;
					end else if (tick_q == 9'd5) r = R_ACK2;
					else if (tick_q == 9'd6) r = sec_q[15:8];
					else if (tick_q == 9'd7) begin
						r = sec_q[7:0];
						n_crun = sec_q[15:8] ^ sec_q[7:0];
					end else if (tick_q <= T_DATA_LAST_RD) begin
						if (sec_ok) begin
							go_rd = 1'b1;
						end else begin
							r = R_ZERO;
							n_off = off_q + 7'd1;
						end
					end else if (tick_q == T_SUM_RD) r = crun_q;
					else if (tick_q == T_END_RD) r = R_GOOD;
					else r = R_CMDACK;
				end
				C_WRITE: begin
					if (tick_q == 9'd0) r = R_ACK1;
					else if (tick_q == 9'd1) r = R_ACK2;
					else if (tick_q == 9'd2) r = R_ZERO;
					else if (tick_q == 9'd3) begin
						n_sec = {d, 8'd0};
						r = d;
					end else if (tick_q == 9'd4) begin
						n_sec = sec_q | {8'd0, d};
						n_crun = sec_q[15:8] ^ d;
						r = d;
					end else if (tick_q <= T_DATA_LAST_WR) begin
						buf_we = 1'b1;
						n_crun = crun_q ^ d;
						r = d;
					end else if (tick_q == T_SUM_WR) begin
						n_crcv = d;
						r = R_CMDACK;
					end else if (tick_q == T_ACK_WR) r = R_ACK2;
					else begin
						if (tick_q == T_STAT_WR) begin
							if (!sec_ok) r = R_FF;
							else if (crcv_q == crun_q) begin
								n_dir = 1'b0;
								n_pend = 1'b1;
								r = R_GOOD;
							end else r = R_BADSUM;
						end else r = R_FF;
						n_cmd = C_IDLE;
						n_tick = 9'd0;
						n_off = 7'd0;
					end
				end
				C_PING: begin
					if (tick_q <= 9'd3) r = R_ZERO;
					else if (tick_q == 9'd4) r = R_FF;
					else r = R_CMDACK;
				end
				C_TITLE: begin
					if (tick_q <= 9'd1) r = R_ZERO;
					else if (tick_q == 9'd2) begin
						n_tlen = d;
						r = R_ZERO;
					end else if (tsub <= {1'b0, tlen_q}) r = R_ZERO;
					else r = R_CMDACK;
				end
				default: begin
					r = R_FF;
					n_cmd = C_IDLE;
					n_tick = 9'd0;
					n_off = 7'd0;
				end
			endcase
		end
		emit = (st_q == S_EXEC) && head_valid && !go_rd;
		if (st_q == S_RDWAIT) begin
			emit = 1'b1;
		end
		buf_we = buf_we && emit && (st_q == S_EXEC);
	end

	assign pop = emit;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = R_ZERO;
		if (st_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (st_q == S_COMMIT && ccnt_q != '0) begin
			mem_we = 1'b1;
			mem_waddr = wr_full[MEM_AW-1:0];
			mem_wdata = buf_rdata;
		end
	end

	mccs_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_card (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mccs_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_wbuf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (d),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			cmd_q <= C_IDLE;
			tick_q <= 9'd0;
			sec_q <= 16'd0;
			off_q <= 7'd0;
			crcv_q <= 8'd0;
			crun_q <= 8'd0;
			pend_q <= 1'b0;
			dir_q <= 1'b1;
			tlen_q <= 8'd0;
			clr_q <= '0;
			ccnt_q <= '0;
			done <= 1'b0;
			data_out <= 8'd0;
		end else begin
			done <= emit;
			case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MEM_AW'(MEM_DEPTH - 1)) st_q <= S_EXEC;
				end
				S_EXEC: begin
					if (head_valid) begin
						if (go_rd) begin
							st_q <= S_RDWAIT;
						end else begin
							data_out <= r;
							cmd_q <= n_cmd;
							tick_q <= n_tick;
							sec_q <= n_sec;
							off_q <= n_off;
							crun_q <= n_crun ^ ((eff == C_READ && tick_q >= 9'd8 &&
								tick_q <= T_DATA_LAST_RD && !head.release_sel) ? r : 8'd0);
							crcv_q <= n_crcv;
							pend_q <= n_pend;
							dir_q <= n_dir;
							tlen_q <= n_tlen;
							if (go_commit) begin
								ccnt_q <= '0;
								st_q <= S_COMMIT;
							end
						end
					end
				end
				S_RDWAIT: begin
					data_out <= mem_rdata;
					crun_q <= crun_q ^ mem_rdata;
					off_q <= off_q + 7'd1;
					tick_q <= tick_inc;
					cmd_q <= C_READ;
					st_q <= S_EXEC;
				end
				S_COMMIT: begin
					ccnt_q <= ccnt_q + 1'b1;
					if (ccnt_q == (BUF_AW + 1)'(SECTOR_BYTES)) begin
						pend_q <= 1'b0;
						if (sec_q == 16'd0) dir_q <= 1'b1;
						st_q <= S_EXEC;
					end
				end
				default: st_q <= S_EXEC;
			endcase
		end
	end
endmodule

### rtl/memory_card_slave_protocol_core.sv
// Top level of the memory card slave protocol core.
`timescale 1ns / 1ps
// Each accepted request (start high while busy is low) yields exactly one reply on
// data_out, marked by a one-cycle done strobe that cannot be held off. A request is
// registered into the queue, then answered by the protocol engine with done and
// data_out registered; a sector data read adds a read-wait state for the card memory
// read port. After reset the card memory is cleared one byte per cycle, and a release
// with a pending good write copies the buffered sector into card memory; the two-entry
// request queue keeps accepting until full, with busy high only while it is full.
module memory_card_slave_protocol_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       op,
	input  logic [7:0] data_in,
	output logic       done,
	output logic [7:0] data_out
);
	import mccs_pkg::*;

	req_t head;
	logic head_valid;
	logic pop;

	mccs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.data_in    (data_in),
		.busy       (busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	mccs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.data_out   (data_out)
	);
endmodule

### tb/memory_card_slave_protocol_core_tb.sv
// Self-checking testbench for the memory card slave protocol core: byte protocol, sector store.
`timescale 1ns / 1ps
module memory_card_slave_protocol_core_tb;
	import mccs_pkg::*;

	localparam int STALL_LIMIT = 400000;

	typedef struct {
		bit         rel;
		logic [7:0] d;
		bit         typed;
		logic [7:0] r;
	} row_t;

	logic clk, arst_n, start, op, busy, done;
	logic [7:0] data_in, data_out;

	logic [7:0] card [MEM_DEPTH];
	logic [7:0] wbuf [SECTOR_BYTES];
	cmd_t       cmd;
	int         tick;
	logic [15:0] sector;
	logic [6:0] offs;
	logic [7:0] sum_rx, sum_run, title_len;
	bit         pend, dir_unread;

	logic [7:0] replies_due [$];
	int         errs = 0;
	int         sent = 0;
	int         stall = 0;
	bit         quiet = 0;

	memory_card_slave_protocol_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .data_in(data_in), .done(done), .data_out(data_out)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic void go_idle();
		cmd = C_IDLE;
		tick = 0;
		offs = 0;
	endfunction

	function automatic void bump();
		if (tick < 511)
			tick++;
	endfunction

	function automatic logic [7:0] card_reply(bit rel, logic [7:0] d);
		logic [7:0] r;
		if (rel) begin
			go_idle();
			if (pend && sector < SECTOR_COUNT) begin
				for (int i = 0; i < SECTOR_BYTES; i++)
					card[sector * SECTOR_BYTES + i] = wbuf[i];
				if (sector == 0)
					dir_unread = 1;
			end
			pend = 0;
			return R_FF;
		end
		if (cmd == C_ACCESS) begin
			case (d)
				B_READ:  cmd = C_READ;
				B_WRITE: cmd = C_WRITE;
				B_PING:  cmd = C_PING;
				B_TITLE: cmd = C_TITLE;
				default: cmd = C_ERROR;
			endcase
		end
		case (cmd)
			C_IDLE: begin
				cmd = (d == B_ACCESS) ? C_ACCESS : C_ERROR;
				r = dir_unread ? R_FLAG : R_ZERO;
			end
			C_READ: begin
				if (tick == 0) r = R_ACK1;
				else if (tick == 1) r = R_ACK2;
				else if (tick == 2) r = R_ZERO;
				else if (tick == 3) begin
					sector = {d, 8'h00};
					r = d;
				end else if (tick == 4) begin
					sector[7:0] = d;
					r = R_CMDACK;
				end else if (tick == 5) r = R_ACK2;
				else if (tick == 6) r = sector[15:8];
				else if (tick == 7) begin
					r = sector[7:0];
					sum_run = sector[15:8] ^ sector[7:0];
				end else if (tick <= 135) begin
					r = (sector >= SECTOR_COUNT) ? R_ZERO :
						card[sector * SECTOR_BYTES + offs];
					sum_run ^= r;
					offs++;
				end else if (tick == 136) r = sum_run;
				else if (tick == 137) r = R_GOOD;
				else r = R_CMDACK;
				bump();
			end
			C_WRITE: begin
				if (tick == 0) r = R_ACK1;
				else if (tick == 1) r = R_ACK2;
				else if (tick == 2) r = R_ZERO;
				else if (tick == 3) begin
					sector = {d, 8'h00};
					r = d;
				end else if (tick == 4) begin
					sector[7:0] = d;
					sum_run = sector[15:8] ^ d;
					r = d;
				end else if (tick <= 132) begin
					wbuf[tick - 5] = d;
					sum_run ^= d;
					r = d;
				end else if (tick == 133) begin
					sum_rx = d;
					r = R_CMDACK;
				end else if (tick == 134) r = R_ACK2;
				if (tick >= 135) begin
					if (sector >= SECTOR_COUNT) r = R_FF;
					else if (sum_rx == sum_run) begin
						dir_unread = 0;
						pend = 1;
						r = R_GOOD;
					end else r = R_BADSUM;
					go_idle();
				end else bump();
			end
			C_PING: begin
				r = (tick <= 3) ? R_ZERO : (tick == 4) ? R_FF : R_CMDACK;
				bump();
			end
			C_TITLE: begin
				if (tick == 2) title_len = d;
				r = (tick <= 2 || tick - 3 <= title_len) ? R_ZERO : R_CMDACK;
				bump();
			end
			default: begin
				r = R_FF;
				go_idle();
			end
		endcase
		return r;
	endfunction

	task automatic send(bit rel, logic [7:0] d, bit typed = 0, logic [7:0] r = 8'h00);
		logic [7:0] want;
		while (!quiet && $urandom_range(99) < 27) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		op <= rel;
		data_in <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		want = card_reply(rel, d);
		replies_due.push_back(typed ? r : want);
		sent++;
	endtask

	function automatic logic [15:0] pick_sector();
		int k;
		k = $urandom_range(99);
		if (k < 15) return 16'd0;
		if (k < 22) return 16'(SECTOR_COUNT - 1);
		if (k < 32) return 16'($urandom_range(SECTOR_COUNT, 65535));
		return 16'($urandom_range(15));
	endfunction

	task automatic write_seq();
		logic [15:0] s;
		logic [7:0] sum, b;
		int cut;
		s = pick_sector();
		cut = ($urandom_range(9) == 0) ? $urandom_range(1, 135) : 1000;
		send(0, B_ACCESS);
		send(0, B_WRITE);
		send(0, 8'($urandom));
		send(0, 8'($urandom));
		send(0, s[15:8]);
		if (cut < 4) return;
		send(0, s[7:0]);
		sum = s[15:8] ^ s[7:0];
		for (int i = 0; i < SECTOR_BYTES; i++) begin
			b = 8'($urandom);
			sum ^= b;
			send(0, b);
			if (i + 5 > cut) return;
		end
		send(0, ($urandom_range(4) == 0) ? 8'($urandom) : sum);
		send(0, 8'($urandom));
		send(0, 8'($urandom));
	endtask

	task automatic read_seq();
		logic [15:0] s;
		s = pick_sector();
		send(0, B_ACCESS);
		send(0, B_READ);
		send(0, 8'($urandom));
		send(0, 8'($urandom));
		send(0, s[15:8]);
		send(0, s[7:0]);
		repeat ($urandom_range(120, 140)) send(0, 8'($urandom));
	endtask

	initial begin
		row_t rows [24] = '{
			'{1, 8'hFF, 1, R_FF}, '{0, B_ACCESS, 1, R_FLAG}, '{0, 8'h53, 1, R_FF},
			'{0, 8'h00, 1, R_FLAG}, '{0, 8'hFF, 1, R_FF}, '{0, B_ACCESS, 1, R_FLAG},
			'{0, B_PING, 1, R_ZERO}, '{0, 8'h00, 1, R_ZERO}, '{0, 8'hFF, 1, R_ZERO},
			'{0, 8'h00, 1, R_ZERO}, '{0, 8'h00, 1, R_FF}, '{0, 8'hAA, 1, R_CMDACK},
			'{1, 8'h00, 1, R_FF}, '{0, B_ACCESS, 1, R_FLAG}, '{0, B_TITLE, 1, R_ZERO},
			'{0, 8'h00, 1, R_ZERO}, '{0, 8'h01, 1, R_ZERO}, '{0, 8'h00, 1, R_ZERO},
			'{0, 8'h00, 1, R_ZERO}, '{0, 8'h00, 1, R_CMDACK}, '{1, 8'h55, 1, R_FF},
			'{0, B_ACCESS, 0, 0}, '{0, B_READ, 0, 0}, '{1, 8'h00, 1, R_FF}
		};
		int k;
		for (int i = 0; i < MEM_DEPTH; i++) card[i] = 0;
		for (int i = 0; i < SECTOR_BYTES; i++) wbuf[i] = 0;
		sector = 0;
		sum_rx = 0;
		sum_run = 0;
		title_len = 0;
		pend = 0;
		dir_unread = 1;
		go_idle();
		arst_n = 0;
		start = 0;
		op = 0;
		data_in = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		foreach (rows[i]) send(rows[i].rel, rows[i].d, rows[i].typed, rows[i].r);
		while (sent < 1650) begin
			quiet = (sent > 700 && sent < 1000);
			if (sent > 1100 && sent < 1300) begin
				start <= 0;
				while (replies_due.size() != 0) @(posedge clk);
			end
			send(1, 8'($urandom));
			k = $urandom_range(99);
			if (k < 40) write_seq();
			else if (k < 70) read_seq();
			else if (k < 80) begin
				send(0, B_ACCESS);
				send(0, B_PING);
				repeat (($urandom_range(30) == 0) ? 520 : $urandom_range(8)) send(0, 8'($urandom));
			end else if (k < 90) begin
				send(0, B_ACCESS);
				send(0, B_TITLE);
				send(0, 8'($urandom));
				send(0, ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(12)));
				repeat ($urandom_range(20)) send(0, 8'($urandom));
			end else
				repeat ($urandom_range(1, 6)) send($urandom_range(7) == 0, 8'($urandom));
		end
		send(1, 8'h00);
		start <= 0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errs == 0 && replies_due.size() == 0)
			$display("PASS memory_card_slave_protocol_core");
		else
			$display("FAIL memory_card_slave_protocol_core");
		$finish;
	end

	always @(posedge clk) begin
		if (done) begin
			if (replies_due.size() == 0) begin
				$error("data_out: no reply expected, got %h", data_out);
				errs++;
			end else if (data_out !== replies_due[0]) begin
				$error("data_out: expected %h, actual %h", replies_due[0], data_out);
				errs++;
				void'(replies_due.pop_front());
			end else
				void'(replies_due.pop_front());
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy))
			stall <= 0;
		else if (stall >= STALL_LIMIT) begin
			$display("FAIL memory_card_slave_protocol_core");
			$finish;
		end else
			stall <= stall + 1;
	end
endmodule

### memory_card_slave_protocol_core.f
rtl/mccs_pkg.sv
rtl/mccs_ram.sv
rtl/mccs_front.sv
rtl/mccs_back.sv
rtl/memory_card_slave_protocol_core.sv
tb/memory_card_slave_protocol_core_tb.sv
